// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clk_i, disabled while reset is asserted.
`define VG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a signal carries no unknown bits once reset is released.
`define VG_ASSERT_KNOWN(lbl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(sig)) else $error(msg);
`endif

// ----- rtl/core/vgrm_pkg.sv -----
// Package with the shared types and constants of the voxel grid running mean core.
package vgrm_pkg;
  localparam int unsigned Capacity  = 4096;
  localparam int unsigned FracBits  = 16;
  localparam logic [31:0] InvResReset = 32'd655360;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [2:0] StMerged = 3'd0;
  localparam logic [2:0] StNew    = 3'd1;
  localparam logic [2:0] StFull   = 3'd2;
  localparam logic [2:0] StBadIdx = 3'd3;
  localparam logic [2:0] StClear  = 3'd4;

  typedef struct packed {
    logic        start;
    logic signed [32:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

// ----- rtl/core/vgrm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vgrm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/vgrm_div.sv -----
// Radix-2 restoring divider of a signed 33-bit dividend by an unsigned 32-bit divisor.
module vgrm_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vgrm_pkg::div_req_t   req_i,
  output logic                 done_o,
  output logic signed [32:0]   quot_o
);
  logic [32:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [31:0] dsr_q;
  logic        neg_q, busy_q, busy_d, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[32]} - {2'b00, dsr_q};
    if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[32]};
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= done_d;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend[32] ? 33'(-req_i.dividend) : 33'(req_i.dividend);
      neg_q <= req_i.dividend[32];
      dsr_q <= req_i.divisor;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ----- rtl/core/voxel_grid_running_mean_core.sv -----
// Top level of the voxel grid running mean core: sequencer, cell tables and datapath.
//
//  channel   | direction | handshake              | word
//  ----------+-----------+------------------------+----------------------------------
//  command   | in        | start_i, busy_o        | operation, x, y, z, intensity, index
//  result    | out       | done_o strobe          | status, index, means, count, used
//  config    | in        | inv_resolution_we_i    | inv_resolution
//
// A clear goes straight to the output step; a read fetches the cell and then outputs it. An
// add quantizes the three axes one after the other on the shared multiplier, then runs a
// key search that probes the stored keys one at a time on the single key RAM read port,
// fetches the cell, runs four divides on the shared serial divider, writes back and
// outputs; when the table is full the divides and the write-back are skipped. done_o is
// registered from the output step; the receiver cannot stall. Reset clears the sequencer
// and cell count and sets the resolution to its reset value; no clearing pass.
`include "assert_macros.svh"
module voxel_grid_running_mean_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          operation_i,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic signed [31:0]  z_i,
  input  logic [15:0]         intensity_i,
  input  logic [11:0]         read_index_i,
  input  logic                inv_resolution_we_i,
  input  logic [31:0]         inv_resolution_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [11:0]         cell_index_o,
  output logic signed [31:0]  mean_x_o,
  output logic signed [31:0]  mean_y_o,
  output logic signed [31:0]  mean_z_o,
  output logic [15:0]         mean_intensity_o,
  output logic [31:0]         point_count_o,
  output logic [12:0]         cells_used_o
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_QUANT = 10'b0000000010,
    S_SRCH  = 10'b0000000100,
    S_SCHK  = 10'b0000001000,
    S_RDW   = 10'b0000010000,
    S_RDG   = 10'b0000100000,
    S_DIVS  = 10'b0001000000,
    S_DIVW  = 10'b0010000000,
    S_WRB   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] inv_res_q;
  logic [12:0] used_q;
  logic [1:0]  op_q;
  logic signed [31:0] p_q [4];
  logic [1:0]  axis_q;
  logic [15:0] key_q [3];
  logic [11:0] idx_q;
  logic [12:0] probe_q;
  logic        new_q;
  logic [2:0]  st_q;
  logic signed [31:0] m_q [4];
  logic [31:0] cnt_q;
  logic        out_q;

  // Shared multiplier: magnitude of one coordinate times inv_resolution.
  logic signed [31:0] cur_p;
  logic        neg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] qint;
  logic [32:0] qup;
  logic [15:0] qkey;

  assign cur_p = p_q[axis_q];
  assign neg   = cur_p[31];
  assign mag   = neg ? 32'(-cur_p) : cur_p;
  assign prod  = 64'(mag) * 64'(inv_res_q);
  assign qint  = prod[63:2*vgrm_pkg::FracBits];
  assign qup   = 33'(qint) + 33'(neg && (prod[2*vgrm_pkg::FracBits-1:0] != '0));

  always_comb begin
    if (neg) begin
      qkey = (qup > 33'd32768) ? 16'h8000 : 16'(17'h10000 - 17'(qup));
    end else begin
      qkey = (qup > 33'd32767) ? 16'h7fff : qup[15:0];
    end
  end

  // Cell tables.
  logic        key_we, dat_we;
  logic [11:0] key_ra, dat_ra, key_wa, dat_wa;
  logic [47:0] key_rd;
  logic [143:0] dat_wd, dat_rd;

  vgrm_ram #(.Width(48), .Depth(vgrm_pkg::Capacity)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i({key_q[0], key_q[1], key_q[2]}),
    .raddr_i(key_ra), .rdata_o(key_rd)
  );
  vgrm_ram #(.Width(144), .Depth(vgrm_pkg::Capacity)) u_data (
    .clk_i, .we_i(dat_we), .waddr_i(dat_wa), .wdata_i(dat_wd),
    .raddr_i(dat_ra), .rdata_o(dat_rd)
  );

  assign key_ra = probe_q[11:0];
  assign dat_ra = idx_q;
  assign key_wa = idx_q;
  assign dat_wa = idx_q;
  assign key_we = (state_q == S_WRB) && new_q;
  assign dat_we = (state_q == S_WRB);
  assign dat_wd = {m_q[0], m_q[1], m_q[2], m_q[3][15:0], cnt_q};

  // Shared divider for the four mean updates.
  vgrm_pkg::div_req_t dreq;
  logic dv_done;
  logic signed [32:0] dv_quot;
  assign dreq.start    = (state_q == S_DIVS);
  assign dreq.dividend = 33'(p_q[axis_q]) - 33'(m_q[axis_q]);
  assign dreq.divisor  = cnt_q;

  vgrm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(dv_done), .quot_o(dv_quot));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (operation_i)
            vgrm_pkg::OpAdd:   state_d = S_QUANT;
            vgrm_pkg::OpRead:  state_d = S_RDW;
            vgrm_pkg::OpClear: state_d = S_OUT;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_QUANT: if (axis_q == 2'd2) state_d = S_SRCH;
      S_SRCH:  state_d = (probe_q >= used_q) ? S_RDW : S_SCHK;
      S_SCHK:  state_d = (key_rd == {key_q[0], key_q[1], key_q[2]}) ? S_RDW : S_SRCH;
      S_RDW:   state_d = S_RDG;
      S_RDG: begin
        if (op_q == vgrm_pkg::OpRead || st_q == vgrm_pkg::StFull) state_d = S_OUT;
        else state_d = S_DIVS;
      end
      S_DIVS:  state_d = S_DIVW;
      S_DIVW: begin
        if (dv_done) state_d = (axis_q == 2'd3) ? S_WRB : S_DIVS;
      end
      S_WRB:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      inv_res_q <= vgrm_pkg::InvResReset;
      used_q    <= '0;
      out_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      out_q   <= (state_q == S_OUT);
      if (inv_resolution_we_i) inv_res_q <= inv_resolution_i;
      if (state_q == S_IDLE && start_i && operation_i == vgrm_pkg::OpClear) used_q <= '0;
      if (state_q == S_WRB && new_q) used_q <= used_q + 13'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q    <= operation_i;
        p_q[0]  <= x_i;
        p_q[1]  <= y_i;
        p_q[2]  <= z_i;
        p_q[3]  <= 32'($unsigned(intensity_i));
        axis_q  <= '0;
        // A clear reports cell index zero.
        idx_q   <= (operation_i == vgrm_pkg::OpClear) ? '0 : read_index_i;
        probe_q <= '0;
        new_q   <= 1'b0;
        st_q    <= (operation_i == vgrm_pkg::OpClear) ? vgrm_pkg::StClear : vgrm_pkg::StMerged;
        for (int k = 0; k < 4; k++) m_q[k] <= '0;
        cnt_q   <= '0;
      end
      S_QUANT: begin
        key_q[axis_q] <= qkey;
        axis_q        <= axis_q + 2'd1;
      end
      S_SRCH: begin
        if (probe_q >= used_q) begin
          // Key not found: allocate or drop.
          if (used_q >= 13'(vgrm_pkg::Capacity)) begin
            st_q  <= vgrm_pkg::StFull;
            idx_q <= '0;
          end else begin
            st_q  <= vgrm_pkg::StNew;
            new_q <= 1'b1;
            idx_q <= used_q[11:0];
          end
        end
      end
      S_SCHK: begin
        if (key_rd == {key_q[0], key_q[1], key_q[2]}) idx_q <= probe_q[11:0];
        else probe_q <= probe_q + 13'd1;
      end
      S_RDG: begin
        axis_q <= '0;
        if (op_q == vgrm_pkg::OpRead) begin
          if (13'(idx_q) >= used_q) begin
            st_q <= vgrm_pkg::StBadIdx;
          end else begin
            m_q[0] <= dat_rd[143:112];
            m_q[1] <= dat_rd[111:80];
            m_q[2] <= dat_rd[79:48];
            m_q[3] <= 32'(dat_rd[47:32]);
            cnt_q  <= dat_rd[31:0];
          end
        end else if (st_q != vgrm_pkg::StFull) begin
          if (!new_q) begin
            m_q[0] <= dat_rd[143:112];
            m_q[1] <= dat_rd[111:80];
            m_q[2] <= dat_rd[79:48];
            m_q[3] <= 32'(dat_rd[47:32]);
            cnt_q  <= (dat_rd[31:0] == '1) ? dat_rd[31:0] : dat_rd[31:0] + 32'd1;
          end else begin
            cnt_q  <= 32'd1;
          end
        end
      end
      S_DIVW: begin
        if (dv_done) begin
          m_q[axis_q] <= m_q[axis_q] + dv_quot[31:0];
          axis_q      <= axis_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      status_o         <= st_q;
      cell_index_o     <= idx_q;
      mean_x_o         <= m_q[0];
      mean_y_o         <= m_q[1];
      mean_z_o         <= m_q[2];
      mean_intensity_o <= m_q[3][15:0];
      point_count_o    <= cnt_q;
      cells_used_o     <= used_q;
    end
  end

  `VG_ASSERT(a_used_bound, used_q <= 13'(vgrm_pkg::Capacity), "cell count above capacity")
  `VG_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `VG_ASSERT(a_done_after_out, done_o |-> $past(state_q == S_OUT), "result without output step")
  `VG_ASSERT_KNOWN(a_busy_known, busy_o, "busy is unknown")
endmodule
